// ===== design/tkpe_pkg.sv =====
`default_nettype none
// tkpe_pkg: shared constants, register indexes and key table for the touch keypad PIN block.
// No dependencies; compiled first.
package tkpe_pkg;

	// PIN buffer depth default
	localparam int PIN_DIGITS_DEF = 4;

	// register indexes on the config port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AWAKE_POLARITY  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ASLEEP_POLARITY = 2'd2;

	// register reset values
	localparam logic [7:0] IDLE_LIMIT_RST      = 8'd20;
	localparam logic [7:0] AWAKE_POLARITY_RST  = 8'hFF;
	localparam logic [7:0] ASLEEP_POLARITY_RST = 8'h00;

	// character codes
	localparam logic [6:0] KEY_NONE   = 7'd0;
	localparam logic [6:0] KEY_BS     = 7'd8;
	localparam logic [6:0] KEY_CR     = 7'd13;
	localparam logic [7:0] CHAR_BLANK = 8'd95;  // underscore
	localparam logic [7:0] PREV_KEY_RST = 8'd81; // 'Q', never a real key

	localparam logic [7:0] LED_RST      = 8'hFF;  // forces a write on first poll
	localparam logic [7:0] IDLE_MAX     = 8'hFF;

	// character of sensor mask bit idx+1
	function automatic logic [6:0] key_char(input logic [3:0] idx);
		logic [6:0] c;
		case (idx)
			4'd0:    c = 7'd52;  // 4
			4'd1:    c = 7'd55;  // 7
			4'd2:    c = 7'd54;  // 6
			4'd3:    c = 7'd49;  // 1
			4'd4:    c = 7'd53;  // 5
			4'd5:    c = 7'd56;  // 8
			4'd6:    c = 7'd48;  // 0
			4'd7:    c = 7'd50;  // 2
			4'd8:    c = 7'd51;  // 3
			4'd9:    c = KEY_CR;
			4'd10:   c = 7'd57;  // 9
			4'd11:   c = KEY_BS;
			default: c = KEY_NONE;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== design/tkpe_ifs.sv =====
`default_nettype none
// tkpe_ifs: valid/ready channel interfaces for keypad polls and results.
// No dependencies.
interface tkpe_poll_if;
	logic       valid;
	logic       ready;
	logic [7:0] button_status_low;
	logic [7:0] button_status_high;
	logic [7:0] group_status;

	modport source (output valid, output button_status_low, output button_status_high,
		output group_status, input ready);
	modport sink (input valid, input button_status_low, input button_status_high,
		input group_status, output ready);
endinterface

interface tkpe_result_if;
	logic        valid;
	logic        ready;
	logic [6:0]  key_code;
	logic        prox;
	logic [7:0]  led_low_value;
	logic        led_low_write;
	logic [7:0]  led_high_value;
	logic        led_high_write;
	logic        feedback_pulse;
	logic [31:0] pin_text;
	logic [2:0]  pin_length;
	logic        polarity_write;
	logic [7:0]  polarity_value;
	logic        idle_expired;

	modport source (output valid, output key_code, output prox, output led_low_value,
		output led_low_write, output led_high_value, output led_high_write,
		output feedback_pulse, output pin_text, output pin_length, output polarity_write,
		output polarity_value, output idle_expired, input ready);
	modport sink (input valid, input key_code, input prox, input led_low_value,
		input led_low_write, input led_high_value, input led_high_write,
		input feedback_pulse, input pin_text, input pin_length, input polarity_write,
		input polarity_value, input idle_expired, output ready);
endinterface
`default_nettype wire

// ===== design/touch_keypad_pin_entry.sv =====
`default_nettype none
// touch_keypad_pin_entry: capacitive keypad poll decoder, LED drive, PIN buffer and idle sleep.
// Depends on tkpe_pkg and the channel interfaces in tkpe_ifs.sv.
//
// Usage:
//  - poll (sink): one transfer per keypad poll, carrying the two button status bytes and the
//    group status byte. result (source): one transfer per poll with key code, LED bytes and
//    write strobes, feedback pulse, PIN text/length, polarity write and idle flag.
//  - cfg_we/cfg_index/cfg_wdata: write-only registers (idle_limit, awake_polarity,
//    asleep_polarity), taken at any edge with cfg_we high; unknown indexes are dropped.
//    Write them only while no poll is in flight.
//  - A taken poll passes the input register, then the result register, before it shows up on
//    result. Throughput: one poll per cycle, limited only by the result register.
//  - All decode, PIN update and idle counting is one combinational pass from the input register
//    into the result register; the keypad state updates in the same edge the result loads.
//  - Stall: while result.ready is low the finished result holds, one more poll can sit in the
//    input register, and poll.ready drops until the result register frees.
//  - Reset (arst_n low): registers return to defaults, PIN reads all underscores, LED history
//    is 8'hFF so the first poll always raises both LED write strobes, LEDs start asleep so the
//    first active poll writes the awake polarity.
module touch_keypad_pin_entry #(
	parameter int PIN_DIGITS = tkpe_pkg::PIN_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	tkpe_poll_if.sink                          poll,
	tkpe_result_if.source                      result,
	input  wire logic                          cfg_we,
	input  wire logic [tkpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                    cfg_wdata
);
	import tkpe_pkg::*;

	// position counts 0..PIN_DIGITS inclusive
	localparam int PW = $clog2(PIN_DIGITS + 1);

	// config registers
	logic [7:0] idle_limit_q, awake_pol_q, asleep_pol_q;

	// input stage
	logic       valid_s1;
	logic [7:0] btn_lo_s1, btn_hi_s1, grp_s1;

	// keypad state
	logic [7:0]    last_led_lo_q, last_led_hi_q;
	logic          saw_cs8_q;
	logic [7:0]    prev_key_q;
	logic [7:0]    pin_chars_q [PIN_DIGITS];
	logic [PW-1:0] pin_pos_q;
	logic [7:0]    idle_cnt_q;
	logic          leds_awake_q;

	// result register
	logic        res_valid_q;
	logic [6:0]  key_q;
	logic        prox_q;
	logic [7:0]  led_lo_q, led_hi_q;
	logic        wr_lo_q, wr_hi_q, pulse_q;
	logic [31:0] text_q;
	logic [2:0]  len_q;
	logic        pol_wr_q;
	logic [7:0]  pol_val_q;
	logic        expired_q;

	// handshake: the input stage moves on when the result register is empty or being drained
	logic accept, advance;
	assign advance    = valid_s1 && (!res_valid_q || result.ready);
	assign poll.ready = !valid_s1 || advance;
	assign accept     = poll.valid && poll.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_limit_q <= IDLE_LIMIT_RST;
			awake_pol_q  <= AWAKE_POLARITY_RST;
			asleep_pol_q <= ASLEEP_POLARITY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IDLE_LIMIT:      idle_limit_q <= cfg_wdata;
				REG_AWAKE_POLARITY:  awake_pol_q  <= cfg_wdata;
				REG_ASLEEP_POLARITY: asleep_pol_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			btn_lo_s1 <= poll.button_status_low;
			btn_hi_s1 <= poll.button_status_high;
			grp_s1    <= poll.group_status;
		end
	end

	// ---------------------------------------------------------------- decode
	// mask bit n is sensor CS(n+1); bit 0 proximity, bit 7 CS8 (also set by group tap/hold)
	logic [13:0] mask;
	always_comb begin
		mask       = {btn_hi_s1, btn_lo_s1[5:0]};
		mask[7]    = btn_hi_s1[1] | (grp_s1[3:0] != 4'd0);
	end

	logic [7:0] led_lo, led_hi;
	always_comb begin
		led_lo    = 8'd0;
		led_hi    = 8'd0;
		led_lo[7] = mask[7];
		led_lo[0] = mask[11];
		led_hi[0] = mask[8];
		led_hi[1] = mask[9];
		led_hi[2] = mask[10] | mask[12];  // CS11 and CS13 share one LED
	end

	logic pulse, prox;
	assign pulse = mask[7] && !saw_cs8_q;
	assign prox  = mask[0];

	// lowest touched key wins; CS14 is unused
	logic [6:0] key;
	always_comb begin
		key = KEY_NONE;
		for (int i = 12; i >= 1; i--) begin
			if (mask[i]) begin
				key = key_char(4'(i - 1));
			end
		end
	end

	// ---------------------------------------------------------------- PIN buffer
	logic [7:0]    key8;
	logic          is_bs, is_cr;
	logic [7:0]    chars_n [PIN_DIGITS];
	logic [PW-1:0] pos_n;
	logic [7:0]    prev_n;
	assign key8  = {1'b0, key};
	assign is_bs = (key == KEY_BS);
	assign is_cr = (key == KEY_CR);

	always_comb begin
		chars_n = pin_chars_q;
		pos_n   = pin_pos_q;
		prev_n  = prev_key_q;
		// a held key repeats the previous code and is ignored
		if (key8 != prev_key_q) begin
			prev_n = key8;
			if (key != KEY_NONE) begin
				if (is_bs) begin
					if (pos_n != '0) begin
						pos_n = pos_n - PW'(1);
					end
					for (int j = 0; j < PIN_DIGITS; j++) begin
						if (pos_n == PW'(j)) begin
							chars_n[j] = CHAR_BLANK;
						end
					end
				end
				// full buffer wraps, enter clears
				if (pos_n >= PW'(PIN_DIGITS) || is_cr) begin
					for (int j = 0; j < PIN_DIGITS; j++) begin
						chars_n[j] = CHAR_BLANK;
					end
					pos_n = '0;
				end
				if (!is_cr && !is_bs) begin
					for (int j = 0; j < PIN_DIGITS; j++) begin
						if (pos_n == PW'(j)) begin
							chars_n[j] = key8;
						end
					end
					pos_n = pos_n + PW'(1);
				end
			end
		end
	end

	logic [31:0] text;
	for (genvar g = 0; g < 4; g++) begin : g_text
		if (g < PIN_DIGITS) begin : g_chr
			assign text[8*g +: 8] = chars_n[g];
		end else begin : g_pad
			assign text[8*g +: 8] = CHAR_BLANK;
		end
	end

	logic [31:0] pos_wide;
	assign pos_wide = 32'(pos_n);

	// ---------------------------------------------------------------- idle / sleep
	logic [7:0] idle_n;
	logic       expired, pol_wr;
	logic [7:0] pol_val;
	always_comb begin
		if (prox || key != KEY_NONE) begin
			idle_n = 8'd0;
		end else if (idle_cnt_q != IDLE_MAX) begin
			idle_n = idle_cnt_q + 8'd1;
		end else begin
			idle_n = idle_cnt_q;
		end
		expired = (idle_n >= idle_limit_q);
		pol_wr  = 1'b0;
		pol_val = 8'd0;
		if (expired && leds_awake_q) begin
			pol_wr  = 1'b1;
			pol_val = asleep_pol_q;
		end else if (!expired && !leds_awake_q) begin
			pol_wr  = 1'b1;
			pol_val = awake_pol_q;
		end
	end

	// ---------------------------------------------------------------- state and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_led_lo_q <= LED_RST;
			last_led_hi_q <= LED_RST;
			saw_cs8_q     <= 1'b0;
			prev_key_q    <= PREV_KEY_RST;
			for (int j = 0; j < PIN_DIGITS; j++) begin
				pin_chars_q[j] <= CHAR_BLANK;
			end
			pin_pos_q     <= '0;
			idle_cnt_q    <= 8'd0;
			leds_awake_q  <= 1'b0;
		end else if (advance) begin
			last_led_lo_q <= led_lo;
			last_led_hi_q <= led_hi;
			saw_cs8_q     <= mask[7];
			prev_key_q    <= prev_n;
			pin_chars_q   <= chars_n;
			pin_pos_q     <= pos_n;
			idle_cnt_q    <= idle_n;
			leds_awake_q  <= !expired;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_q     <= key;
			prox_q    <= prox;
			led_lo_q  <= led_lo;
			led_hi_q  <= led_hi;
			wr_lo_q   <= (led_lo != last_led_lo_q);
			wr_hi_q   <= (led_hi != last_led_hi_q);
			pulse_q   <= pulse;
			text_q    <= text;
			len_q     <= pos_wide[2:0];
			pol_wr_q  <= pol_wr;
			pol_val_q <= pol_val;
			expired_q <= expired;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.key_code       = key_q;
	assign result.prox           = prox_q;
	assign result.led_low_value  = led_lo_q;
	assign result.led_low_write  = wr_lo_q;
	assign result.led_high_value = led_hi_q;
	assign result.led_high_write = wr_hi_q;
	assign result.feedback_pulse = pulse_q;
	assign result.pin_text       = text_q;
	assign result.pin_length     = len_q;
	assign result.polarity_write = pol_wr_q;
	assign result.polarity_value = pol_val_q;
	assign result.idle_expired   = expired_q;

	// ---------------------------------------------------------------- checks
	// write position never runs past the buffer end
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pin_pos_q <= PW'(PIN_DIGITS))
		else $error("PIN position beyond buffer");

	// a held result reflects the current LED sleep state
	a_awake_match: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (leds_awake_q == !expired_q))
		else $error("LED sleep state out of step with result");

	// no polarity value without a polarity write
	a_pol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.polarity_write) |-> (result.polarity_value == 8'd0))
		else $error("polarity value without write");

	// a feedback pulse only comes with the CS8 LED lit
	a_pulse_led: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.feedback_pulse) |-> result.led_low_value[7])
		else $error("feedback pulse without CS8");

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for touch_keypad_pin_entry; a per-poll predictor in the bench
// checks every result transfer. Needs tkpe_pkg, the channel interfaces in tkpe_ifs.sv and the RTL.
module tb_top;
	import tkpe_pkg::*;

	localparam int PIN_LEN = PIN_DIGITS_DEF;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;  // decoded by nothing
	localparam int QUIET_LIMIT = 1000;  // cycles with no transfer on either channel
	localparam int MAX_REPORTS = 10;
	localparam int HOLD_OFF_CYCLES = 80;

	// sensor numbers are mask bit positions; bit 0 is proximity
	localparam int SENSOR_CS8       = 7;
	localparam int SENSOR_ENTER     = 10;
	localparam int SENSOR_BACKSPACE = 12;
	localparam int SENSOR_SPARE     = 13;  // CS14, wired to nothing

	// characters of sensors 1..12, sensor 1 in the top byte
	localparam logic [8*12-1:0] SENSOR_CHARS = {"476158023", 1'b0, KEY_CR, "9", 1'b0, KEY_BS};

	typedef struct packed {
		logic [6:0]  key_code;
		logic        prox;
		logic [7:0]  led_low_value;
		logic        led_low_write;
		logic [7:0]  led_high_value;
		logic        led_high_write;
		logic        feedback_pulse;
		logic [31:0] pin_text;
		logic [2:0]  pin_length;
		logic        polarity_write;
		logic [7:0]  polarity_value;
		logic        idle_expired;
	} keypad_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_wdata;

	tkpe_poll_if   poll_ch ();
	tkpe_result_if res_ch ();

	touch_keypad_pin_entry dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.poll      (poll_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// ---------------------------------------------------------------------------------------
	// Predictor state: registers plus keypad history, advanced once per accepted poll
	// ---------------------------------------------------------------------------------------
	logic [7:0] idle_limit_reg;
	logic [7:0] awake_pol_reg;
	logic [7:0] asleep_pol_reg;
	logic [7:0] led_low_hist;
	logic [7:0] led_high_hist;
	logic       cs8_seen;
	logic [7:0] held_key;
	logic [7:0] pin_buf [PIN_LEN];
	int         pin_pos;
	logic [7:0] idle_cnt;
	logic       leds_on;

	keypad_result_t expected_results [$];

	int  failures;
	int  polls_sent;
	int  quiet_cycles;
	int  rx_hold_len;  // set by a test right after a transfer, counted down by the receiver
	int  rx_wait;
	bit  tx_gaps_on;
	bit  rx_gaps_on;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_pin();
		for (int i = 0; i < PIN_LEN; i++)
			pin_buf[i] = CHAR_BLANK;
	endfunction

	// mostly back-to-back, sometimes a few cycles, rarely a long stretch
	function automatic int pick_gap(input bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// One poll through the keypad logic: merge, LEDs, feedback, decode, PIN, idle/sleep.
	function automatic keypad_result_t predict_poll(input logic [7:0] lo, hi, grp);
		logic [13:0]    mask;
		logic [7:0]     led_lo;
		logic [7:0]     led_hi;
		logic [7:0]     key;
		keypad_result_t r;
		r = '0;
		// bits 6,7 of the low byte fall off; any CS8 group tap/hold lands on bit 7
		mask = {hi, lo[5:0]};
		if (grp[3:0] != 4'd0)
			mask[SENSOR_CS8] = 1'b1;

		led_lo = {mask[SENSOR_CS8], 6'd0, mask[11]};
		led_hi = {5'd0, mask[10] | mask[12], mask[9], mask[8]};
		r.led_low_value  = led_lo;
		r.led_high_value = led_hi;
		r.led_low_write  = led_lo != led_low_hist;
		r.led_high_write = led_hi != led_high_hist;
		led_low_hist     = led_lo;
		led_high_hist    = led_hi;

		// feedback only on the rising edge of CS8
		r.feedback_pulse = mask[SENSOR_CS8] & ~cs8_seen;
		cs8_seen         = mask[SENSOR_CS8];

		// lowest touched sensor wins; scan down so the last hit is the lowest
		key = {1'b0, KEY_NONE};
		for (int i = 12; i >= 1; i--)
			if (mask[i])
				key = SENSOR_CHARS[8*(12-i) +: 8];
		r.prox     = mask[0];
		r.key_code = key[6:0];

		// held key is ignored; release (no key) re-arms the same key
		if (key != held_key) begin
			held_key = key;
			if (key != KEY_NONE) begin
				if (key == KEY_BS) begin
					if (pin_pos > 0)
						pin_pos--;
					if (pin_pos < PIN_LEN)
						pin_buf[pin_pos] = CHAR_BLANK;
				end
				if (pin_pos >= PIN_LEN || key == KEY_CR) begin
					clear_pin();
					pin_pos = 0;
				end
				if (key != KEY_CR && key != KEY_BS) begin
					if (pin_pos < PIN_LEN)
						pin_buf[pin_pos] = key;
					pin_pos++;
				end
			end
		end

		if (mask[0] || key != KEY_NONE)
			idle_cnt = 8'd0;
		else if (idle_cnt != IDLE_MAX)
			idle_cnt++;
		r.idle_expired = idle_cnt >= idle_limit_reg;

		if (r.idle_expired) begin
			if (leds_on) begin
				r.polarity_write = 1'b1;
				r.polarity_value = asleep_pol_reg;
				leds_on          = 1'b0;
			end
		end else if (!leds_on) begin
			r.polarity_write = 1'b1;
			r.polarity_value = awake_pol_reg;
			leds_on          = 1'b1;
		end

		for (int i = 0; i < 4; i++)
			r.pin_text[8*i +: 8] = (i < PIN_LEN) ? pin_buf[i] : CHAR_BLANK;
		r.pin_length = 3'(pin_pos);
		return r;
	endfunction

	// ---------------------------------------------------------------------------------------
	// Poll side: drive at the falling edge, transfer seen at the rising edge
	// ---------------------------------------------------------------------------------------
	task automatic send_poll(input logic [7:0] lo, hi, grp);
		int gap;
		gap = pick_gap(tx_gaps_on);
		if (gap > 0) begin
			@(negedge clk);
			poll_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		poll_ch.valid              <= 1'b1;
		poll_ch.button_status_low  <= lo;
		poll_ch.button_status_high <= hi;
		poll_ch.group_status       <= grp;
		do @(posedge clk); while (!poll_ch.ready);
		expected_results.push_back(predict_poll(lo, hi, grp));
		polls_sent++;
	endtask

	// touch pattern as a 14-bit mask; unused byte bits get junk, CS8 sometimes via the group
	task automatic press(input logic [13:0] m);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] grp;
		lo  = {2'($urandom), m[5:0]};
		hi  = m[13:6];
		grp = {4'($urandom), 4'd0};
		if (m[SENSOR_CS8] && $urandom_range(0, 1)) begin
			hi[1]    = 1'b0;
			grp[3:0] = 4'($urandom_range(1, 15));
		end
		send_poll(lo, hi, grp);
	endtask

	// stop offering and wait until every outstanding result has been taken
	task automatic drain_results();
		@(negedge clk);
		poll_ch.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
		drain_results();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_IDLE_LIMIT:      idle_limit_reg = val;
			REG_AWAKE_POLARITY:  awake_pol_reg  = val;
			REG_ASLEEP_POLARITY: asleep_pol_reg = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_config(input logic [7:0] limit, awake, asleep);
		write_reg(REG_IDLE_LIMIT, limit);
		write_reg(REG_AWAKE_POLARITY, awake);
		write_reg(REG_ASLEEP_POLARITY, asleep);
	endtask

	// Mostly keystrokes (press, hold, release), some idle runs to cross the sleep limit,
	// and some raw noise polls.
	task automatic run_random(input int count, input int idle_max);
		int          stop;
		int          kind;
		int          sensor;
		logic [13:0] m;
		stop = polls_sent + count;
		while (polls_sent < stop) begin
			if ($urandom_range(0, 49) == 0) begin
				tx_gaps_on = $urandom_range(0, 3) != 0;
				rx_gaps_on = $urandom_range(0, 3) != 0;
			end
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				sensor = $urandom_range(1, SENSOR_SPARE);
				m      = 14'd1 << sensor;
				// extra touches above the key must not change the decode
				if ($urandom_range(0, 3) == 0)
					m |= 14'($urandom) & ~((14'd1 << (sensor + 1)) - 14'd1);
				if ($urandom_range(0, 4) == 0)
					m[0] = 1'b1;
				repeat ($urandom_range(1, 3)) press(m);
				repeat ($urandom_range(0, 2)) press(14'd0);
			end else if (kind < 85) begin
				repeat ($urandom_range(1, idle_max)) press(14'd0);
			end else begin
				send_poll(8'($urandom), 8'($urandom), 8'($urandom));
			end
		end
	endtask

	// ---------------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------------

	// first poll after reset (forced LED writes, wake), each button status bit alone, group polls
	task automatic test_sensor_sweep();
		send_poll(8'h00, 8'h00, 8'h00);
		for (int i = 0; i < 8; i++)
			send_poll(8'd1 << i, 8'h00, 8'h00);
		for (int i = 0; i < 8; i++)
			send_poll(8'h00, 8'd1 << i, 8'h00);
		send_poll(8'h00, 8'h00, 8'h01);
		send_poll(8'h00, 8'h00, 8'h08);
		send_poll(8'h00, 8'h00, 8'hF0);  // high nibble of group is not CS8
		send_poll(8'hFF, 8'hFF, 8'hFF);
	endtask

	// 1 2 3 4 fills the PIN, 5 wraps it, then backspace and enter
	task automatic test_pin_entry();
		int keys [7];
		keys = '{4, 8, 9, 1, 5, SENSOR_BACKSPACE, SENSOR_ENTER};
		foreach (keys[i])
			press(14'd1 << keys[i]);
	endtask

	// receiver holds off while polls keep coming; the block must fill and stall its input
	task automatic test_backpressure();
		tx_gaps_on = 1'b0;
		press(14'd0);
		rx_hold_len = HOLD_OFF_CYCLES;
		repeat (30)
			send_poll(8'($urandom), 8'($urandom), 8'($urandom));
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_sender_pause();
		run_random(40, 10);
		drain_results();
		run_random(40, 10);
	endtask

	// limit 1, limit 255 with saturation of the idle count, limit 0 (always expired)
	task automatic test_idle_limits();
		set_config(8'd1, 8'h00, 8'hFF);
		run_random(200, 4);
		set_config(IDLE_MAX, 8'($urandom), 8'($urandom));
		tx_gaps_on = 1'b0;
		repeat (260) press(14'd0);
		tx_gaps_on = 1'b1;
		run_random(120, 20);
		set_config(8'd0, 8'($urandom), 8'($urandom));
		run_random(120, 5);
	endtask

	// a write to the undecoded index must leave all registers alone
	task automatic test_unused_index();
		write_reg(REG_UNUSED, 8'($urandom));
		run_random(30, 25);
		set_config(8'($urandom_range(2, 12)), 8'($urandom), 8'($urandom));
		write_reg(REG_UNUSED, 8'($urandom));
		run_random(200, 16);
	endtask

	initial begin
		arst_n                     = 1'b0;
		cfg_we                     = 1'b0;
		cfg_index                  = REG_IDLE_LIMIT;
		cfg_wdata                  = 8'd0;
		poll_ch.valid              = 1'b0;
		poll_ch.button_status_low  = 8'd0;
		poll_ch.button_status_high = 8'd0;
		poll_ch.group_status       = 8'd0;
		res_ch.ready               = 1'b0;
		failures                   = 0;
		polls_sent                 = 0;
		rx_hold_len                = 0;
		rx_wait                    = 0;
		tx_gaps_on                 = 1'b1;
		rx_gaps_on                 = 1'b1;
		// predictor at its reset state
		idle_limit_reg = IDLE_LIMIT_RST;
		awake_pol_reg  = AWAKE_POLARITY_RST;
		asleep_pol_reg = ASLEEP_POLARITY_RST;
		led_low_hist   = LED_RST;
		led_high_hist  = LED_RST;
		cs8_seen       = 1'b0;
		held_key       = PREV_KEY_RST;
		clear_pin();
		pin_pos        = 0;
		idle_cnt       = 8'd0;
		leds_on        = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_sensor_sweep();
		test_pin_entry();
		run_random(300, 25);  // reset register values
		test_backpressure();
		test_sender_pause();
		test_idle_limits();
		test_unused_index();

		drain_results();
		repeat (4) @(posedge clk);
		if (failures == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// ---------------------------------------------------------------------------------------
	// Result side: random ready, long hold-off on request
	// ---------------------------------------------------------------------------------------
	always @(negedge clk) begin
		if (rx_hold_len != 0) begin
			res_ch.ready <= 1'b0;
			rx_hold_len  = rx_hold_len - 1;
		end else if (rx_wait != 0) begin
			res_ch.ready <= 1'b0;
			rx_wait      = rx_wait - 1;
		end else begin
			res_ch.ready <= 1'b1;
			rx_wait      = pick_gap(rx_gaps_on);
		end
	end

	task automatic show_field(input string name, input logic [31:0] want, got);
		if (want !== got)
			$display("    %s: expected %0h, got %0h", name, want, got);
	endtask

	always @(posedge clk) begin : result_check
		keypad_result_t got;
		keypad_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got.key_code       = res_ch.key_code;
			got.prox           = res_ch.prox;
			got.led_low_value  = res_ch.led_low_value;
			got.led_low_write  = res_ch.led_low_write;
			got.led_high_value = res_ch.led_high_value;
			got.led_high_write = res_ch.led_high_write;
			got.feedback_pulse = res_ch.feedback_pulse;
			got.pin_text       = res_ch.pin_text;
			got.pin_length     = res_ch.pin_length;
			got.polarity_write = res_ch.polarity_write;
			got.polarity_value = res_ch.polarity_value;
			got.idle_expired   = res_ch.idle_expired;
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= MAX_REPORTS)
					$display("%0t: result transfer with no poll outstanding", $realtime);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					failures++;
					if (failures <= MAX_REPORTS) begin
						$display("%0t: result mismatch", $realtime);
						show_field("key_code", want.key_code, got.key_code);
						show_field("prox", want.prox, got.prox);
						show_field("led_low_value", want.led_low_value, got.led_low_value);
						show_field("led_low_write", want.led_low_write, got.led_low_write);
						show_field("led_high_value", want.led_high_value, got.led_high_value);
						show_field("led_high_write", want.led_high_write, got.led_high_write);
						show_field("feedback_pulse", want.feedback_pulse, got.feedback_pulse);
						show_field("pin_text", want.pin_text, got.pin_text);
						show_field("pin_length", want.pin_length, got.pin_length);
						show_field("polarity_write", want.polarity_write, got.polarity_write);
						show_field("polarity_value", want.polarity_value, got.polarity_value);
						show_field("idle_expired", want.idle_expired, got.idle_expired);
					end
				end
			end
		end
	end

	// no transfer on either channel for too long means the block is stuck
	always @(posedge clk) begin
		if ((poll_ch.valid && poll_ch.ready) || (res_ch.valid && res_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles = quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule
